// File: hdl/pcs_pkg.sv
package pcs_pkg;

    typedef struct packed {
        logic [62:0]        local_time_ns;
        logic signed [47:0] offset_ns;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] compensation_ppb;
        logic               compensation_valid;
        logic               jump_request;
        logic signed [31:0] drift_ppb;
        logic               synced;
    } t_out_item;

    // configuration register indexes
    localparam logic [2:0] CFG_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_KP_GAIN   = 3'd1;
    localparam logic [2:0] CFG_KI_GAIN   = 3'd2;
    localparam logic [2:0] CFG_KP_MIN    = 3'd3;
    localparam logic [2:0] CFG_KP_MAX    = 3'd4;
    localparam logic [2:0] CFG_KI_MIN    = 3'd5;
    localparam logic [2:0] CFG_KI_MAX    = 3'd6;

    // how one item is handled
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_ACQ   = 2'd1;
    localparam logic [1:0] MODE_RATE  = 2'd2;
    localparam logic [1:0] MODE_TRACK = 2'd3;

    // multiplier operand selects
    localparam logic [2:0] SEL_N_LO  = 3'd0;
    localparam logic [2:0] SEL_N_HI  = 3'd1;
    localparam logic [2:0] SEL_KP_LO = 3'd2;
    localparam logic [2:0] SEL_KP_HI = 3'd3;
    localparam logic [2:0] SEL_KI_LO = 3'd4;
    localparam logic [2:0] SEL_KI_HI = 3'd5;

    localparam int          DIV_BITS = 78;
    localparam int          CNT_W    = 7;
    localparam logic [29:0] NS_PER_S = 30'd1000000000;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       div_init;
        logic       div_step;
        logic       terms;
        logic       finish;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
    } t_sts;

endpackage

// File: hdl/pcs_ctrl.sv
module pcs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  pcs_pkg::t_sts i_sts,
    output pcs_pkg::t_cmd o_cmd
);
    import pcs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_MWAIT = 3'd3;
    localparam logic [2:0] S_DINIT = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_TERM  = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_rate;

    assign w_rate      = (i_sts.mode == MODE_RATE);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                n_cnt = '0;
                if (i_sts.mode == MODE_RATE || i_sts.mode == MODE_TRACK) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = (w_rate ? SEL_N_LO : SEL_KP_LO) + r_cnt[2:0];
                n_cnt         = r_cnt + 1'b1;
                if ((w_rate && r_cnt == CNT_W'(1)) || r_cnt == CNT_W'(3)) begin
                    n_state = S_MWAIT;
                end
            end
            S_MWAIT: begin
                n_state = w_rate ? S_DINIT : S_TERM;
            end
            S_DINIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_BITS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_TERM: begin
                o_cmd.terms = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: hdl/pcs_dp.sv
module pcs_dp #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcs_pkg::t_cmd     i_cmd,
    output pcs_pkg::t_sts     o_sts,
    input  pcs_pkg::t_in_item i_in,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    output pcs_pkg::t_out_item o_out
);
    import pcs_pkg::*;

    localparam logic [71:0] SAT_MAG = 72'd1 << 40;

    // configuration
    logic [31:0]        r_thr;
    logic [23:0]        r_kp_gain, r_ki_gain;
    logic signed [31:0] r_kp_min, r_kp_max, r_ki_min, r_ki_max;

    // servo state
    logic [1:0]         r_phase;
    logic signed [47:0] r_first_off;
    logic [62:0]        r_first_loc;
    logic signed [31:0] r_drift;
    logic               r_synced;

    // item operands
    logic [62:0]        r_loc;
    logic signed [47:0] r_off;
    logic [47:0]        r_offmag, r_nummag;
    logic               r_offneg, r_numneg, r_dneg, r_restart;
    logic [62:0]        r_dmag;
    logic [1:0]         r_mode;

    // arithmetic
    logic [53:0]        r_prod;
    logic [2:0]         r_psel;
    logic               r_pv;
    logic [77:0]        r_acc_a;
    logic [71:0]        r_acc_b;
    logic [77:0]        r_dvd;
    logic [63:0]        r_rem;
    logic [40:0]        r_quo;
    logic signed [31:0] r_kp, r_ki;
    t_out_item          r_out, n_out;

    logic [47:0]        w_offmag, w_nummag;
    logic signed [48:0] w_num;
    logic               w_restart, w_dneg;
    logic [62:0]        w_dmag;
    logic [1:0]         w_mode;
    logic [23:0]        w_ma;
    logic [29:0]        w_mb;
    logic [63:0]        w_rs;
    logic               w_qbit;
    logic [41:0]        w_qn;
    logic signed [31:0] w_rate_drift;

    function automatic logic signed [41:0] gain_term(input logic [71:0] p, input logic neg);
        logic [71:0] sh;
        logic [40:0] mag;
        sh  = p >> GAIN_FRAC_BITS;
        mag = (sh > SAT_MAG) ? 41'(SAT_MAG) : sh[40:0];
        return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    function automatic logic signed [31:0] clamp(input logic signed [41:0] t,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
        logic signed [41:0] v;
        v = (t < 42'(hi)) ? t : 42'(hi);
        v = (v > 42'(lo)) ? v : 42'(lo);
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [43:0] x);
        if (x > 44'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (x < -44'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    assign w_offmag  = i_in.offset_ns[47] ? 48'(-i_in.offset_ns) : i_in.offset_ns;
    assign w_restart = (r_phase == 2'd2) && (r_thr != '0) && ({16'b0, r_thr} <= w_offmag);
    assign w_num     = 49'(r_first_off) - 49'(i_in.offset_ns);
    assign w_nummag  = w_num[48] ? 48'(-w_num) : w_num[47:0];
    assign w_dneg    = i_in.local_time_ns > r_first_loc;
    assign w_dmag    = w_dneg ? i_in.local_time_ns - r_first_loc
                              : r_first_loc - i_in.local_time_ns;

    always_comb begin
        if (i_in.offset_ns == '0) begin
            w_mode = MODE_NONE;
        end else if (w_restart || r_phase == 2'd0 || r_phase == 2'd3) begin
            w_mode = MODE_ACQ;
        end else if (r_phase == 2'd1) begin
            w_mode = MODE_RATE;
        end else begin
            w_mode = MODE_TRACK;
        end
    end

    assign o_sts.mode = r_mode;

    always_comb begin
        unique case (i_cmd.mul_sel)
            SEL_N_LO:  begin w_ma = r_nummag[23:0];  w_mb = NS_PER_S;          end
            SEL_N_HI:  begin w_ma = r_nummag[47:24]; w_mb = NS_PER_S;          end
            SEL_KP_LO: begin w_ma = r_offmag[23:0];  w_mb = {6'b0, r_kp_gain}; end
            SEL_KP_HI: begin w_ma = r_offmag[47:24]; w_mb = {6'b0, r_kp_gain}; end
            SEL_KI_LO: begin w_ma = r_offmag[23:0];  w_mb = {6'b0, r_ki_gain}; end
            SEL_KI_HI: begin w_ma = r_offmag[47:24]; w_mb = {6'b0, r_ki_gain}; end
            default:   begin w_ma = '0;              w_mb = '0;                end
        endcase
    end

    // restoring divider, one quotient bit a cycle, quotient clipped at 2^40
    assign w_rs   = {r_rem[62:0], r_dvd[77]};
    assign w_qbit = w_rs >= {1'b0, r_dmag};
    assign w_qn   = {r_quo, w_qbit};

    // drift after the rate estimate; hold it when the local times match
    assign w_rate_drift = (r_dmag == '0) ? r_drift
                        : sat32((r_numneg != r_dneg)
                            ? 44'(r_drift) - 44'({1'b0, r_quo})
                            : 44'(r_drift) + 44'({1'b0, r_quo}));

    always_comb begin
        n_out           = '0;
        n_out.drift_ppb = r_drift;
        n_out.synced    = r_synced;
        unique case (r_mode)
            MODE_ACQ: begin
                n_out.synced = r_restart ? 1'b0 : r_synced;
            end
            MODE_RATE: begin
                n_out.compensation_ppb   = w_rate_drift;
                n_out.drift_ppb          = w_rate_drift;
                n_out.compensation_valid = 1'b1;
                n_out.jump_request       = 1'b1;
                n_out.synced             = 1'b1;
            end
            MODE_TRACK: begin
                n_out.compensation_ppb   = sat32(44'(r_kp) + 44'(r_ki) + 44'(r_drift));
                n_out.compensation_valid = 1'b1;
                n_out.drift_ppb          = sat32(44'(r_drift) + 44'(r_ki));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= '0;
            r_kp_gain   <= '0;
            r_ki_gain   <= '0;
            r_kp_min    <= 32'sh80000000;
            r_kp_max    <= 32'sh7fffffff;
            r_ki_min    <= 32'sh80000000;
            r_ki_max    <= 32'sh7fffffff;
            r_phase     <= 2'd0;
            r_first_off <= '0;
            r_first_loc <= '0;
            r_drift     <= '0;
            r_synced    <= 1'b0;
            r_mode      <= MODE_NONE;
            r_pv        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_THRESHOLD: r_thr     <= i_cfg_data;
                    CFG_KP_GAIN:   r_kp_gain <= i_cfg_data[23:0];
                    CFG_KI_GAIN:   r_ki_gain <= i_cfg_data[23:0];
                    CFG_KP_MIN:    r_kp_min  <= i_cfg_data;
                    CFG_KP_MAX:    r_kp_max  <= i_cfg_data;
                    CFG_KI_MIN:    r_ki_min  <= i_cfg_data;
                    CFG_KI_MAX:    r_ki_max  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_mode <= w_mode;
            end
            r_pv <= i_cmd.mul_en;
            if (i_cmd.finish) begin
                unique case (r_mode)
                    MODE_ACQ: begin
                        r_first_off <= r_off;
                        r_first_loc <= r_loc;
                        r_phase     <= 2'd1;
                        if (r_restart) begin
                            r_synced <= 1'b0;
                        end
                    end
                    MODE_RATE: begin
                        r_drift  <= w_rate_drift;
                        r_synced <= 1'b1;
                        r_phase  <= 2'd2;
                    end
                    MODE_TRACK: begin
                        r_drift <= sat32(44'(r_drift) + 44'(r_ki));
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_loc     <= i_in.local_time_ns;
            r_off     <= i_in.offset_ns;
            r_offmag  <= w_offmag;
            r_offneg  <= i_in.offset_ns[47];
            r_nummag  <= w_nummag;
            r_numneg  <= w_num[48];
            r_dmag    <= w_dmag;
            r_dneg    <= w_dneg;
            r_restart <= w_restart;
            r_acc_a   <= '0;
            r_acc_b   <= '0;
        end else if (r_pv) begin
            case (r_psel)
                SEL_N_LO, SEL_KP_LO: r_acc_a <= r_acc_a + {24'b0, r_prod};
                SEL_N_HI, SEL_KP_HI: r_acc_a <= r_acc_a + {r_prod, 24'b0};
                SEL_KI_LO:           r_acc_b <= r_acc_b + {18'b0, r_prod};
                SEL_KI_HI:           r_acc_b <= r_acc_b + {r_prod[47:0], 24'b0};
                default: ;
            endcase
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_ma * w_mb;
            r_psel <= i_cmd.mul_sel;
        end
        if (i_cmd.div_init) begin
            r_dvd <= r_acc_a;
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[76:0], 1'b0};
            r_rem <= w_qbit ? w_rs - {1'b0, r_dmag} : w_rs;
            r_quo <= (w_qn > 42'(SAT_MAG)) ? 41'(SAT_MAG) : w_qn[40:0];
        end
        if (i_cmd.terms) begin
            r_kp <= clamp(gain_term(r_acc_a[71:0], r_offneg), r_kp_min, r_kp_max);
            r_ki <= clamp(gain_term(r_acc_b, r_offneg), r_ki_min, r_ki_max);
        end
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

// File: hdl/pi_clock_servo_top.sv
// PI clock servo for time synchronization.
// Input channel (i_in_valid / o_in_ready, payload i_in): one item per clock
// measurement, local time and offset to the reference in ns.
// Output channel (o_out_valid / i_out_ready, payload o_out): one item per
// input item with compensation, jump request, drift estimate and sync flag.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
// high; write only while the block is idle.
// A zero offset or an acquisition sample goes straight to the result. In
// tracking, four 24x30 partial products run on one multiplier, then the
// clamped gain terms are formed. The rate estimate runs the 78-step
// restoring divider that forms 1e9 * offset delta / time delta.
// The input reopens in the same cycle as the result appears.
// One item is worked at a time; the next one is taken once the result has
// moved to the output register.
// Reset: servo returns to acquisition, drift and sync cleared, gains zero,
// clamps open. A stalled receiver holds the result; an item already
// accepted waits in its final step until the output register frees up.
module pi_clock_servo_top #(
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pcs_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pcs_pkg::t_out_item o_out,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    import pcs_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequence the shared multiplier and the divider
    pcs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // servo state, configuration and arithmetic
    pcs_dp #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out      (o_out)
    );

    // a jump is only requested together with a valid compensation
    a_jump_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.jump_request |-> o_out.compensation_valid)
        else $error("jump without compensation");

    // compensation reads zero when it is not to be applied
    a_comp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.compensation_valid |-> o_out.compensation_ppb == '0)
        else $error("nonzero compensation while not valid");

    // an accepted item blocks the input for the next cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken twice in a row");

endmodule
